// File: hdl/wtsf_pkg.sv
// Package for the half / bfloat16 / byte to single-float widener.
// Holds the format selector codes and the field constants; no dependencies.
`timescale 1ns / 1ps
package wtsf_pkg;
  typedef enum logic [1:0] {
    ModeHalf  = 2'd0,
    ModeBf16  = 2'd1,
    ModeByte  = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  localparam logic [4:0]  HalfExpMax = 5'h1F;
  localparam logic [7:0]  BiasSingle = 8'd127;
  localparam logic [7:0]  BiasHalf   = 8'd15;
  localparam logic [31:0] SingleInf  = 32'h7F80_0000;
endpackage

// File: hdl/wtsf_convert.sv
// Combinational widening of one 16-bit element to a single-float pattern.
// Depends on wtsf_pkg.
`timescale 1ns / 1ps
module wtsf_convert (
  input  wtsf_pkg::mode_e mode_i,
  input  logic [15:0]     raw_i,
  output logic [31:0]     single_bits_o
);
  logic [9:0]  man;
  logic [4:0]  ex;
  logic [3:0]  sh;
  logic [9:0]  man_norm;
  logic [7:0]  byte_v;
  logic [2:0]  p;
  logic [22:0] byte_man;
  logic [31:0] half_r;
  logic [31:0] byte_r;

  assign man    = raw_i[9:0];
  assign ex     = raw_i[14:10];
  assign byte_v = raw_i[7:0];

  // leading-one search over the subnormal mantissa
  always_comb begin
    sh = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) sh = 4'(10 - i);
    end
  end

  always_comb begin
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (byte_v[i]) p = 3'(i);
    end
  end

  assign man_norm = 10'(man << sh);
  assign byte_man = 23'({15'd0, byte_v} << (5'd23 - {2'd0, p}));

  always_comb begin
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        half_r = {raw_i[15], 31'd0};
      end else begin
        half_r = {raw_i[15],
                  8'(wtsf_pkg::BiasSingle - wtsf_pkg::BiasHalf + 8'd1 - {4'd0, sh}),
                  man_norm, 13'd0};
      end
    end else if (ex == wtsf_pkg::HalfExpMax) begin
      half_r = {raw_i[15], 31'd0} | wtsf_pkg::SingleInf | {9'd0, man, 13'd0};
    end else begin
      half_r = {raw_i[15],
                8'({3'd0, ex} - wtsf_pkg::BiasHalf + wtsf_pkg::BiasSingle),
                man, 13'd0};
    end
  end

  assign byte_r = (byte_v == 8'd0) ? 32'd0 :
                  {1'b0, 8'(wtsf_pkg::BiasSingle + {5'd0, p}), byte_man};

  always_comb begin
    unique case (mode_i)
      wtsf_pkg::ModeHalf: single_bits_o = half_r;
      wtsf_pkg::ModeBf16: single_bits_o = {raw_i, 16'd0};
      wtsf_pkg::ModeByte: single_bits_o = byte_r;
      default:            single_bits_o = 32'd0;
    endcase
  end
endmodule

// File: hdl/widen_to_single_float.sv
// Top level of the single-float widener: input register, converter, result register.
// Depends on wtsf_pkg and wtsf_convert.
//
//   channel  signals                        direction
//   input    in_valid_i/in_stall_o, mode_i, raw_i        in
//   output   out_valid_o/out_stall_i, single_bits_o      out
//
// One item per clock when the output is not stalled; each item passes the input
// register, then the result register after the converter logic.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not cleared.
// A stall at the output holds the result and backs up into the input stage;
// the input is stalled only while both stages are full and the output stalls.
`timescale 1ns / 1ps
module widen_to_single_float (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] raw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] single_bits_o
);
  logic            in_vld_q, out_vld_q;
  wtsf_pkg::mode_e mode_q;
  logic [15:0]     raw_q;
  logic [31:0]     res_d, res_q;
  logic            adv_out, adv_in;

  // advance the result stage when it is empty or being taken
  assign adv_out    = !out_vld_q || !out_stall_i;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_stall_o = !adv_in;

  wtsf_convert u_convert (
    .mode_i        (mode_q),
    .raw_i         (raw_q),
    .single_bits_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in)  in_vld_q  <= in_valid_i;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      mode_q <= wtsf_pkg::mode_e'(mode_i);
      raw_q  <= raw_i;
    end
    if (adv_out && in_vld_q) res_q <= res_d;
  end

  assign out_valid_o   = out_vld_q;
  assign single_bits_o = res_q;

  // a stalled result must hold its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(single_bits_o))
    else $error("result changed under stall");

  // input is stalled only when both stages are full
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("spurious input stall");

  // an accepted item reaches the result stage next cycle when output is free
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !(out_vld_q && out_stall_i) |=> out_valid_o)
    else $error("item lost between stages");
endmodule

// File: sim/widen_to_single_float_tb.sv
// Testbench for widen_to_single_float: drives mode/raw items in bursts, stalls the output,
// and checks every single-float result against a behavioural predictor.
// Depends on wtsf_pkg and the widen_to_single_float RTL.
`timescale 1ns / 1ps
module widen_to_single_float_tb;
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [15:0] raw_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] single_bits_o;

  // Expected single-float patterns, oldest first
  logic [31:0] widened_q[$];
  int          mismatch_cnt;
  int          gap_left;
  int          burst_left;

  widen_to_single_float DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .raw_i        (raw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .single_bits_o(single_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Widen a half-precision pattern: keep signed zero, renormalise subnormals,
  // carry infinity and NaN payloads unchanged, rebias normals.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    logic [7:0]  sexp;
    int          sh;
    sgn = {h[15], 31'd0};
    ex  = h[14:10];
    man = {1'b0, h[9:0]};
    sh  = 0;
    if (ex == 5'd0) begin
      if (man == 11'd0) return sgn;
      while (!man[10]) begin
        man = man << 1;
        sh++;
      end
      sexp = 8'd113 - sh[7:0];
      return sgn | {1'b0, sexp, man[9:0], 13'd0};
    end
    if (ex == wtsf_pkg::HalfExpMax) begin
      return sgn | wtsf_pkg::SingleInf | {9'd0, h[9:0], 13'd0};
    end
    sexp = {3'd0, ex} - wtsf_pkg::BiasHalf + wtsf_pkg::BiasSingle;
    return sgn | {1'b0, sexp, h[9:0], 13'd0};
  endfunction

  // Exact conversion of an unsigned byte
  function automatic logic [31:0] widen_byte(input logic [7:0] v);
    int          msb;
    logic [31:0] frac;
    if (v == 8'd0) return 32'd0;
    msb = 7;
    while (!v[msb]) msb--;
    frac = ({24'd0, v} << (23 - msb)) & 32'h007F_FFFF;
    return {1'b0, 8'd127 + msb[7:0], 23'd0} | frac;
  endfunction

  function automatic logic [31:0] predict_single(input wtsf_pkg::mode_e m,
                                                 input logic [15:0] r);
    case (m)
      wtsf_pkg::ModeHalf: return widen_half(r);
      wtsf_pkg::ModeBf16: return {r, 16'd0};
      wtsf_pkg::ModeByte: return widen_byte(r[7:0]);
      default:            return 32'd0;
    endcase
  endfunction

  // Send one item, honouring the burst/gap pattern; hold payload while stalled
  task automatic send_item(input wtsf_pkg::mode_e m, input logic [15:0] r);
    if (burst_left == 0) begin
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    raw_i      <= r;
    widened_q.push_back(predict_single(m, r));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int count, input bit half_heavy);
    wtsf_pkg::mode_e m;
    logic [15:0]     r;
    for (int i = 0; i < count; i++) begin
      m = wtsf_pkg::mode_e'($urandom_range(0, 3));
      r = 16'($urandom_range(0, 16'hFFFF));
      // Steer half items toward the exponent extremes
      if (half_heavy && m == wtsf_pkg::ModeHalf) begin
        case ($urandom_range(0, 3))
          0: r[14:10] = 5'd0;
          1: r[14:10] = wtsf_pkg::HalfExpMax;
          default: ;
        endcase
      end
      send_item(m, r);
    end
  endtask

  task automatic test_half_corners();
    send_item(wtsf_pkg::ModeHalf, 16'h0000);
    send_item(wtsf_pkg::ModeHalf, 16'h8000);
    send_item(wtsf_pkg::ModeHalf, 16'h0001);
    send_item(wtsf_pkg::ModeHalf, 16'h83FF);
    send_item(wtsf_pkg::ModeHalf, 16'h0200);
    send_item(wtsf_pkg::ModeHalf, 16'h0400);
    send_item(wtsf_pkg::ModeHalf, 16'h7BFF);
    send_item(wtsf_pkg::ModeHalf, 16'h3C00);
    send_item(wtsf_pkg::ModeHalf, 16'h7C00);
    send_item(wtsf_pkg::ModeHalf, 16'hFC00);
    send_item(wtsf_pkg::ModeHalf, 16'h7C01);
    send_item(wtsf_pkg::ModeHalf, 16'hFFFF);
  endtask

  task automatic test_bf16_corners();
    send_item(wtsf_pkg::ModeBf16, 16'h0000);
    send_item(wtsf_pkg::ModeBf16, 16'hFFFF);
    send_item(wtsf_pkg::ModeBf16, 16'h7FC1);
    send_item(wtsf_pkg::ModeBf16, 16'h8001);
  endtask

  task automatic test_byte_corners();
    send_item(wtsf_pkg::ModeByte, 16'h0000);
    send_item(wtsf_pkg::ModeByte, 16'h0001);
    send_item(wtsf_pkg::ModeByte, 16'h00FF);
    send_item(wtsf_pkg::ModeByte, 16'hFF80);   // upper byte ignored
    send_item(wtsf_pkg::ModeByte, 16'hA503);
  endtask

  task automatic test_unused_mode();
    send_item(wtsf_pkg::ModeNone, 16'hFFFF);
    send_item(wtsf_pkg::ModeNone, 16'h0000);
  endtask

  // Receiver stall pattern: stall at random on about one cycle in six
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 255) < 128) ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (widened_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", single_bits_o);
      end else begin
        if (single_bits_o !== widened_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected %h got %h", widened_q[0], single_bits_o);
          end
        end
        void'(widened_q.pop_front());
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = '0;
    raw_i        = '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_half_corners();
    test_bf16_corners();
    test_byte_corners();
    test_unused_mode();
    send_random(900, 1'b1);
    send_random(900, 1'b0);
    in_valid_i <= 1'b0;
    // Drain: wait for every expected result, then allow the pipeline latency
    while (widened_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
